[rtl/core/rrt_pkg.sv]
// ----------------------------------------------------------------------------
// rrt_pkg
// shared types, constants and command/status structs of the tree extend core
// ----------------------------------------------------------------------------
`default_nettype none
package rrt_pkg;
    localparam int MAX_NODES  = 1024;
    localparam int MAP_CELLS  = 64;
    localparam int CELL_SHIFT = 4;
    localparam int COORD_FRAC = 6;
    localparam int IDX_W      = $clog2(MAX_NODES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int CELL_W     = $clog2(MAP_CELLS);
    localparam int GRID_W     = 2 * CELL_W;
    localparam int GRID_N     = MAP_CELLS * MAP_CELLS;
    localparam int OBS_LO     = MAP_CELLS / 3;
    localparam int OBS_HI     = 2 * MAP_CELLS / 3;
    localparam int CSH        = COORD_FRAC + CELL_SHIFT;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_OUTSIDE = 3'd1,
        ST_OCC     = 3'd2,
        ST_FULL    = 3'd3,
        ST_ZERO    = 3'd4,
        ST_RESTART = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        REG_START_X  = 3'd0,
        REG_START_Y  = 3'd1,
        REG_GOAL_X   = 3'd2,
        REG_GOAL_Y   = 3'd3,
        REG_STEP     = 3'd4,
        REG_TOL      = 3'd5,
        REG_AREA_X   = 3'd6,
        REG_AREA_Y   = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_CLR,
        CMD_SCAN_RD,
        CMD_SCAN_CMP,
        CMD_PARENT,
        CMD_SQRT,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_CHECK,
        CMD_GRID_RD,
        CMD_COMMIT,
        CMD_GOAL
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        logic    sel_y;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic scan_done;
        logic sqrt_done;
        logic div_done;
        logic zero_len;
    } stat_t;
endpackage
`default_nettype wire

[rtl/core/rrt_tree_extend_step_core.sv]
// extend: the time grows with node_total and is set by the nearest-node scan loop
// over the single-port node store, then a 17-step root and two 16-step divides
// throughput: one operation at a time, start is taken while busy is low
// reset: the grid is swept one row per cycle (64 rows) with busy high throughout
`default_nettype none
module rrt_tree_extend_step_core
    import rrt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        op,
    input  wire logic [15:0] sample_x,
    input  wire logic [15:0] sample_y,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output logic             result_valid,
    output logic [2:0]       status,
    output logic [15:0]      new_x,
    output logic [15:0]      new_y,
    output logic [9:0]       node_index,
    output logic [9:0]       parent_index,
    output logic             goal_reached
);
    logic [15:0] start_x_reg, start_y_reg, goal_x_reg, goal_y_reg;
    logic [15:0] step_reg, tol_reg, amx_reg, amy_reg;
    logic [15:0] sx_reg, sy_reg;
    cmd_t  cmd;
    stat_t stat;
    logic  done, restarted;
    logic [2:0]       d_status;
    logic [15:0]      d_x, d_y;
    logic [IDX_W-1:0] d_node, d_parent;
    logic             d_goal;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= 16'd640;
            start_y_reg <= 16'd640;
            goal_x_reg  <= 16'd60000;
            goal_y_reg  <= 16'd60000;
            step_reg    <= 16'd1280;
            tol_reg     <= 16'd1920;
            amx_reg     <= 16'hFFFF;
            amy_reg     <= 16'hFFFF;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_START_X: start_x_reg <= cfg_data;
                REG_START_Y: start_y_reg <= cfg_data;
                REG_GOAL_X:  goal_x_reg  <= cfg_data;
                REG_GOAL_Y:  goal_y_reg  <= cfg_data;
                REG_STEP:    step_reg    <= cfg_data;
                REG_TOL:     tol_reg     <= cfg_data;
                REG_AREA_X:  amx_reg     <= cfg_data;
                REG_AREA_Y:  amy_reg     <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            sx_reg <= sample_x;
            sy_reg <= sample_y;
        end
    end

    rrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .op        (op),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .restarted (restarted)
    );

    rrt_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_sx          (sx_reg),
        .in_sy          (sy_reg),
        .start_x        (start_x_reg),
        .start_y        (start_y_reg),
        .goal_x         (goal_x_reg),
        .goal_y         (goal_y_reg),
        .step_length    (step_reg),
        .goal_tolerance (tol_reg),
        .area_max_x     (amx_reg),
        .area_max_y     (amy_reg),
        .res_status     (d_status),
        .res_x          (d_x),
        .res_y          (d_y),
        .res_node       (d_node),
        .res_parent     (d_parent),
        .res_goal       (d_goal)
    );

    assign result_valid = done;
    assign status       = restarted ? ST_RESTART : d_status;
    assign new_x        = restarted ? 16'd0 : d_x;
    assign new_y        = restarted ? 16'd0 : d_y;
    assign node_index   = restarted ? 10'd0 : 10'(d_node);
    assign parent_index = restarted ? 10'd0 : 10'(d_parent);
    assign goal_reached = restarted ? 1'b0 : d_goal;

`ifndef SYNTH
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result without operation");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("repeated result");
    a_restart_status: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && restarted) |-> (status == ST_RESTART && node_index == 10'd0))
        else $error("bad restart result");
`endif
endmodule
`default_nettype wire

[rtl/core/rrt_datapath.sv]
// ----------------------------------------------------------------------------
// rrt_datapath
// node store, occupancy grid, nearest scan, square root, divider and checks
// ----------------------------------------------------------------------------
`default_nettype none
module rrt_datapath
    import rrt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    output stat_t            stat,
    input  wire logic [15:0] in_sx,
    input  wire logic [15:0] in_sy,
    input  wire logic [15:0] start_x,
    input  wire logic [15:0] start_y,
    input  wire logic [15:0] goal_x,
    input  wire logic [15:0] goal_y,
    input  wire logic [15:0] step_length,
    input  wire logic [15:0] goal_tolerance,
    input  wire logic [15:0] area_max_x,
    input  wire logic [15:0] area_max_y,
    output logic [2:0]       res_status,
    output logic [15:0]      res_x,
    output logic [15:0]      res_y,
    output logic [IDX_W-1:0] res_node,
    output logic [IDX_W-1:0] res_parent,
    output logic             res_goal
);
    localparam logic [MAP_CELLS-1:0] OBS_ROW =
        (MAP_CELLS'(1) << OBS_HI) - (MAP_CELLS'(1) << OBS_LO);

    logic [15:0]       mem_x [MAX_NODES];
    logic [15:0]       mem_y [MAX_NODES];
    logic [MAP_CELLS-1:0] grid [MAP_CELLS];

    logic [15:0]       rdx_reg, rdy_reg;
    logic [CNT_W-1:0]  total_reg;
    logic [CNT_W-1:0]  scan_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic [IDX_W-1:0]  best_reg;
    logic [33:0]       bestd_reg;
    logic              first_reg;
    logic [CELL_W:0]   clr_reg;
    logic [15:0]       px_reg, py_reg;
    logic [33:0]       rem_reg;
    logic [16:0]       root_reg;
    logic [4:0]        cnt_reg;
    logic [32:0]       num_reg;
    logic [16:0]       quo_reg;
    logic [17:0]       drem_reg;
    logic [16:0]       ox_reg, oy_reg;
    logic [17:0]       nx_reg, ny_reg;
    logic [2:0]        st_reg;
    logic [MAP_CELLS-1:0] grow_reg;
    logic              goal_reg;

    logic [15:0]       ax, ay;
    logic [31:0]       sqx, sqy;
    logic [33:0]       dist_sq;
    logic [16:0]       adx, ady;
    logic [16:0]       amag;
    logic [32:0]       num_init;
    logic [17:0]       dtrial;
    logic [17:0]       nxs, nys;
    logic [15:0]       agx, agy;
    logic [31:0]       sgx, sgy;
    logic [CELL_W-1:0] cx, cy;
    logic [31:0]       tol2;
    logic [32:0]       gd;
    logic [5:0]        sq_pos;
    logic [35:0]       sq_cat;
    logic [19:0]       sq_try;
    logic              obs_hit;
    logic              commit_ok;

    assign ax  = (in_sx >= rdx_reg) ? in_sx - rdx_reg : rdx_reg - in_sx;
    assign ay  = (in_sy >= rdy_reg) ? in_sy - rdy_reg : rdy_reg - in_sy;
    assign sqx = 32'(ax) * 32'(ax);
    assign sqy = 32'(ay) * 32'(ay);
    assign dist_sq = 34'(sqx) + 34'(sqy);
    assign adx = (in_sx >= px_reg) ? 17'(in_sx - px_reg) : 17'(px_reg - in_sx);
    assign ady = (in_sy >= py_reg) ? 17'(in_sy - py_reg) : 17'(py_reg - in_sy);
    assign amag = cmd.sel_y ? ady : adx;
    assign num_init = 33'(step_length) * 33'(amag) + 33'(root_reg[16:1]);
    assign dtrial = {drem_reg[16:0], num_reg[32]};
    assign cx = nx_reg[CSH+CELL_W-1:CSH];
    assign cy = ny_reg[CSH+CELL_W-1:CSH];
    assign agx = (nx_reg[15:0] >= goal_x) ? nx_reg[15:0] - goal_x : goal_x - nx_reg[15:0];
    assign agy = (ny_reg[15:0] >= goal_y) ? ny_reg[15:0] - goal_y : goal_y - ny_reg[15:0];
    assign sgx = 32'(agx) * 32'(agx);
    assign sgy = 32'(agy) * 32'(agy);
    assign gd = 33'(sgx) + 33'(sgy);
    assign tol2 = 32'(goal_tolerance) * 32'(goal_tolerance);
    assign nxs = (in_sx >= px_reg) ? 18'(px_reg) + 18'(ox_reg) : 18'(px_reg) - 18'(ox_reg);
    assign nys = (in_sy >= py_reg) ? 18'(py_reg) + 18'(oy_reg) : 18'(py_reg) - 18'(oy_reg);

    // sqrt step candidate: (root<<2|01) vs remainder with next two radicand bits
    assign sq_pos = 6'd33 - {cnt_reg, 1'b0};
    assign sq_cat = {rem_reg, bestd_reg[sq_pos -: 2]};
    assign sq_try = {1'b0, root_reg, 2'b01};

    assign obs_hit = (clr_reg >= (CELL_W+1)'(OBS_LO)) && (clr_reg < (CELL_W+1)'(OBS_HI));
    assign commit_ok = (cmd.op == CMD_COMMIT) && (st_reg == ST_OK) && !grow_reg[cy]
                       && (total_reg < CNT_W'(MAX_NODES));

    assign stat.clr_done  = (clr_reg == (CELL_W+1)'(MAP_CELLS));
    assign stat.scan_done = (scan_reg == total_reg);
    assign stat.sqrt_done = (cnt_reg == 5'd17);
    assign stat.div_done  = (cnt_reg == 5'd17);
    assign stat.zero_len  = (ox_reg == 17'd0) && (oy_reg == 17'd0);

    // node store
    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_SCAN_RD)
        begin
            rdx_reg <= mem_x[scan_reg[IDX_W-1:0]];
            rdy_reg <= mem_y[scan_reg[IDX_W-1:0]];
        end
        else if (cmd.op == CMD_PARENT)
        begin
            rdx_reg <= mem_x[best_reg];
            rdy_reg <= mem_y[best_reg];
        end
        if (cmd.op == CMD_CLR && clr_reg == '0)
        begin
            mem_x[0] <= start_x;
            mem_y[0] <= start_y;
        end
        else if (commit_ok)
        begin
            mem_x[total_reg[IDX_W-1:0]] <= nx_reg[15:0];
            mem_y[total_reg[IDX_W-1:0]] <= ny_reg[15:0];
        end
    end

    // grid rows, one row per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_CLR && !stat.clr_done)
        begin
            grow_reg <= '0;
            grid[clr_reg[CELL_W-1:0]] <= obs_hit ? OBS_ROW : '0;
        end
        else if (cmd.op == CMD_GRID_RD)
            grow_reg <= grid[cx];
        else if (commit_ok)
            grid[cx] <= grow_reg | (MAP_CELLS'(1) << cy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= CNT_W'(1);
            clr_reg   <= '0;
            scan_reg  <= '0;
            cnt_reg   <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                CMD_CLR:
                begin
                    total_reg <= CNT_W'(1);
                    if (!stat.clr_done)
                        clr_reg <= clr_reg + 1'b1;
                end
                CMD_LOAD:
                begin
                    scan_reg  <= '0;
                    clr_reg   <= '0;
                    first_reg <= 1'b1;
                end
                CMD_SCAN_RD:
                begin
                    cmp_idx_reg <= scan_reg[IDX_W-1:0];
                    scan_reg    <= scan_reg + 1'b1;
                end
                CMD_SCAN_CMP:
                begin
                    first_reg <= 1'b0;
                    if (first_reg || dist_sq <= bestd_reg)
                    begin
                        bestd_reg <= dist_sq;
                        best_reg  <= cmp_idx_reg;
                    end
                end
                CMD_PARENT:
                begin
                    rem_reg  <= 34'd0;
                    root_reg <= 17'd0;
                    cnt_reg  <= '0;
                end
                CMD_SQRT:
                begin
                    // restoring sqrt, two radicand bits a step
                    px_reg <= rdx_reg;
                    py_reg <= rdy_reg;
                    if (!stat.sqrt_done)
                    begin
                        if (sq_cat >= 36'(sq_try))
                        begin
                            rem_reg  <= 34'(sq_cat - 36'(sq_try));
                            root_reg <= {root_reg[15:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg  <= 34'(sq_cat);
                            root_reg <= {root_reg[15:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                CMD_DIV_INIT:
                    cnt_reg <= '0;
                CMD_DIV_STEP:
                begin
                    if (cnt_reg < 5'd16)
                        cnt_reg <= cnt_reg + 1'b1;
                    else
                        cnt_reg <= 5'd17;
                end
                CMD_CHECK:
                begin
                    nx_reg <= nxs;
                    ny_reg <= nys;
                end
                CMD_GRID_RD:
                begin
                    if (stat.zero_len)
                        st_reg <= ST_ZERO;
                    else if (nx_reg[17] || ny_reg[17] || nx_reg[15:0] >= area_max_x
                             || ny_reg[15:0] >= area_max_y || nx_reg[16] || ny_reg[16]
                             || (nx_reg[15:0] >> CSH) >= 16'(MAP_CELLS)
                             || (ny_reg[15:0] >> CSH) >= 16'(MAP_CELLS))
                        st_reg <= ST_OUTSIDE;
                    else
                        st_reg <= ST_OK;
                end
                CMD_COMMIT:
                begin
                    if (st_reg == ST_OK)
                    begin
                        if (grow_reg[cy])
                            st_reg <= ST_OCC;
                        else if (total_reg >= CNT_W'(MAX_NODES))
                            st_reg <= ST_FULL;
                        else
                            total_reg <= total_reg + 1'b1;
                    end
                    goal_reg <= 1'b0;
                end
                CMD_GOAL:
                    goal_reg <= (gd < 33'(tol2));
                default:
                begin
                end
            endcase
        end
    end

    // divider: remainder preloaded with the top dividend bits, quotient fits 16 bits
    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_PARENT)
        begin
            ox_reg <= '0;
            oy_reg <= '0;
        end
        else if (cmd.op == CMD_DIV_INIT)
        begin
            num_reg  <= {num_init[15:0], 17'd0};
            drem_reg <= {1'b0, num_init[32:16]};
            quo_reg  <= '0;
        end
        else if (cmd.op == CMD_DIV_STEP && cnt_reg < 5'd17)
        begin
            if (cnt_reg == 5'd16)
            begin
                if (cmd.sel_y)
                    oy_reg <= quo_reg;
                else
                    ox_reg <= quo_reg;
            end
            else
            begin
                num_reg <= {num_reg[31:0], 1'b0};
                if (root_reg != '0 && dtrial >= {1'b0, root_reg})
                begin
                    drem_reg <= dtrial - {1'b0, root_reg};
                    quo_reg  <= {quo_reg[15:0], 1'b1};
                end
                else
                begin
                    drem_reg <= dtrial;
                    quo_reg  <= {quo_reg[15:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        res_status = st_reg;
        res_x      = nx_reg[17] ? 16'd0 : (nx_reg[16] ? 16'hFFFF : nx_reg[15:0]);
        res_y      = ny_reg[17] ? 16'd0 : (ny_reg[16] ? 16'hFFFF : ny_reg[15:0]);
        if (st_reg == ST_ZERO)
        begin
            res_x = px_reg;
            res_y = py_reg;
        end
        res_node   = (st_reg == ST_OK) ? 10'(total_reg - 1'b1) : '0;
        res_parent = best_reg;
        res_goal   = (st_reg == ST_OK) ? goal_reg : 1'b0;
    end
endmodule
`default_nettype wire

[rtl/core/rrt_ctrl.sv]
// ----------------------------------------------------------------------------
// rrt_ctrl
// sequencer of the reset grid sweep and of one extend or restart operation
// ----------------------------------------------------------------------------
`default_nettype none
module rrt_ctrl
    import rrt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic op,
    input  wire stat_t stat,
    output cmd_t      cmd,
    output logic      busy,
    output logic      done,
    output logic      restarted
);
    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_CLR, S_RD, S_CMP, S_PAR, S_SQRT, S_DIVX0, S_DIVX,
        S_DIVY0, S_DIVY, S_CHK, S_GRD, S_COMMIT, S_GOAL, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   rst_op_reg;

    always_comb
    begin
        state_next  = state_reg;
        cmd.op      = CMD_NONE;
        cmd.sel_y   = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                cmd.op = CMD_CLR;
                if (stat.clr_done) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = CMD_LOAD;
                    state_next = op ? S_CLR : S_RD;
                end
            end
            S_CLR:
            begin
                cmd.op = CMD_CLR;
                if (stat.clr_done) state_next = S_DONE;
            end
            S_RD:   begin cmd.op = CMD_SCAN_RD; state_next = S_CMP; end
            S_CMP:
            begin
                cmd.op = CMD_SCAN_CMP;
                state_next = stat.scan_done ? S_PAR : S_RD;
            end
            S_PAR:  begin cmd.op = CMD_PARENT; state_next = S_SQRT; end
            S_SQRT:
            begin
                cmd.op = CMD_SQRT;
                if (stat.sqrt_done) state_next = S_DIVX0;
            end
            S_DIVX0: begin cmd.op = CMD_DIV_INIT; state_next = S_DIVX; end
            S_DIVX:
            begin
                cmd.op = CMD_DIV_STEP;
                if (stat.div_done) state_next = S_DIVY0;
            end
            S_DIVY0: begin cmd.op = CMD_DIV_INIT; cmd.sel_y = 1'b1; state_next = S_DIVY; end
            S_DIVY:
            begin
                cmd.op = CMD_DIV_STEP;
                cmd.sel_y = 1'b1;
                if (stat.div_done) state_next = S_CHK;
            end
            S_CHK:    begin cmd.op = CMD_CHECK; state_next = S_GRD; end
            S_GRD:    begin cmd.op = CMD_GRID_RD; state_next = S_COMMIT; end
            S_COMMIT: begin cmd.op = CMD_COMMIT; state_next = S_GOAL; end
            S_GOAL:   begin cmd.op = CMD_GOAL; state_next = S_DONE; end
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            rst_op_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && start)
                rst_op_reg <= op;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_DONE);
    assign restarted = rst_op_reg;
endmodule
`default_nettype wire
